>>> design/acge_pkg.sv
// shared types and constants for the compressor gain envelope block
// no dependencies; used by every module of the block
package acge_pkg;

  localparam int SampleW = 32;
  localparam int GainW   = 24;
  localparam int CountW  = 16;
  localparam int IdxW    = 3;
  localparam int FracW   = 23;

  localparam logic [GainW-1:0] GAIN_UNITY = 24'h80_0000;
  localparam logic [GainW-1:0] GAIN_MAX   = 24'hFF_FFFF;

  typedef enum logic [IdxW-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_ATTACK_LEN   = 3'd1,
    REG_RELEASE_LEN  = 3'd2,
    REG_HOLD_LEN     = 3'd3,
    REG_REDUCED_GAIN = 3'd4,
    REG_ATTACK_STEP  = 3'd5,
    REG_RELEASE_STEP = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_ATTACK  = 4'b0010,
    PH_HOLD    = 4'b0100,
    PH_RELEASE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [SampleW-1:0] threshold_level;
    logic [CountW-1:0]  attack_samples;
    logic [CountW-1:0]  release_samples;
    logic [CountW-1:0]  hold_samples;
    logic [GainW-1:0]   reduced_gain;
    logic [GainW-1:0]   attack_step;
    logic [GainW-1:0]   release_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold_level: 32'd644245094,
    attack_samples:  16'd3000,
    release_samples: 16'd2000,
    hold_samples:    16'd1000,
    reduced_gain:    24'd4194304,
    attack_step:     24'd1398,
    release_step:    24'd2097
  };

endpackage

>>> design/acge_cfg.sv
// configuration register file of the compressor
// depends on acge_pkg
module acge_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [acge_pkg::IdxW-1:0]     cfg_index,
  input  logic [acge_pkg::SampleW-1:0]  cfg_wdata,
  output acge_pkg::cfg_t                cfg
);

  acge_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= acge_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (acge_pkg::reg_idx_t'(cfg_index))
        acge_pkg::REG_THRESHOLD:    cfg_r.threshold_level <= cfg_wdata;
        acge_pkg::REG_ATTACK_LEN:   cfg_r.attack_samples  <= cfg_wdata[15:0];
        acge_pkg::REG_RELEASE_LEN:  cfg_r.release_samples <= cfg_wdata[15:0];
        acge_pkg::REG_HOLD_LEN:     cfg_r.hold_samples    <= cfg_wdata[15:0];
        acge_pkg::REG_REDUCED_GAIN: cfg_r.reduced_gain    <= cfg_wdata[23:0];
        acge_pkg::REG_ATTACK_STEP:  cfg_r.attack_step     <= cfg_wdata[23:0];
        acge_pkg::REG_RELEASE_STEP: cfg_r.release_step    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/acge_env.sv
// attack / hold / release gain envelope state machine
// depends on acge_pkg; advances once per request taken into the multiply stage
module acge_env (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [acge_pkg::SampleW-1:0]  mag,
  input  acge_pkg::cfg_t                cfg,
  output logic [acge_pkg::GainW-1:0]    gain_nxt
);

  acge_pkg::phase_t                 phase_r, phase_nxt;
  logic [acge_pkg::CountW-1:0]      cnt_r, cnt_nxt;
  logic [acge_pkg::GainW-1:0]       gain_r;

  always_comb begin
    logic                        loud;
    logic                        quiet;
    logic [acge_pkg::GainW:0]    sum;
    acge_pkg::phase_t            ph;
    logic [acge_pkg::CountW-1:0] cnt;
    logic [acge_pkg::GainW-1:0]  g;

    loud  = mag > cfg.threshold_level;
    quiet = mag < cfg.threshold_level;
    ph    = phase_r;
    cnt   = cnt_r;
    g     = gain_r;
    sum   = {1'b0, gain_r} + {1'b0, cfg.release_step};

    if (loud) begin
      if (gain_r >= cfg.reduced_gain &&
          (phase_r == acge_pkg::PH_IDLE || phase_r == acge_pkg::PH_RELEASE)) begin
        ph  = acge_pkg::PH_ATTACK;
        cnt = cfg.attack_samples;
      end
      if (ph == acge_pkg::PH_HOLD) cnt = cfg.hold_samples;
    end

    if (quiet && gain_r <= acge_pkg::GAIN_UNITY && cnt == '0 &&
        ph == acge_pkg::PH_HOLD) begin
      ph  = acge_pkg::PH_RELEASE;
      cnt = cfg.release_samples;
    end

    unique case (ph)
      acge_pkg::PH_ATTACK: begin
        if (cnt != '0 && gain_r > cfg.reduced_gain) begin
          g   = (gain_r > cfg.attack_step) ? gain_r - cfg.attack_step : '0;
          cnt = cnt - 16'd1;
        end else begin
          ph  = acge_pkg::PH_HOLD;
          cnt = cfg.hold_samples;
        end
      end
      acge_pkg::PH_HOLD: begin
        if (cnt != '0) begin
          cnt = cnt - 16'd1;
        end else begin
          ph  = acge_pkg::PH_RELEASE;
          cnt = cfg.release_samples;
        end
      end
      acge_pkg::PH_RELEASE: begin
        if (cnt != '0 && gain_r < acge_pkg::GAIN_UNITY) begin
          g   = sum[acge_pkg::GainW] ? acge_pkg::GAIN_MAX : sum[acge_pkg::GainW-1:0];
          cnt = cnt - 16'd1;
        end else begin
          ph = acge_pkg::PH_IDLE;
        end
      end
      acge_pkg::PH_IDLE: begin
        if (gain_r < acge_pkg::GAIN_UNITY) g = acge_pkg::GAIN_UNITY;
      end
      default: begin
        ph = acge_pkg::PH_IDLE;
      end
    endcase

    phase_nxt = ph;
    cnt_nxt   = cnt;
    gain_nxt  = g;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= acge_pkg::PH_IDLE;
      cnt_r   <= '0;
      gain_r  <= acge_pkg::GAIN_UNITY;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      gain_r  <= gain_nxt;
    end
  end

endmodule

>>> design/acge_scale.sv
// sample magnitude times gain, truncated toward zero, sign restored, saturated
// depends on acge_pkg; purely combinational
module acge_scale (
  input  logic                                neg,
  input  logic [acge_pkg::SampleW-1:0]        mag,
  input  logic [acge_pkg::GainW-1:0]          gain,
  output logic signed [acge_pkg::SampleW-1:0] sample_out
);

  logic [acge_pkg::SampleW+acge_pkg::GainW-1:0] prod;
  logic [acge_pkg::SampleW:0]                   q;

  assign prod = {{acge_pkg::GainW{1'b0}}, mag} * {{acge_pkg::SampleW{1'b0}}, gain};
  assign q    = prod[acge_pkg::SampleW+acge_pkg::GainW-1:acge_pkg::FracW];

  always_comb begin
    if (neg) begin
      if (q >= 33'h0_8000_0000) sample_out = 32'sh8000_0000;
      else                      sample_out = signed'(~q[31:0] + 32'd1);
    end else begin
      if (q > 33'h0_7FFF_FFFF)  sample_out = 32'sh7FFF_FFFF;
      else                      sample_out = signed'(q[31:0]);
    end
  end

endmodule

>>> design/audio_compressor_gain_envelope.sv
// top level of the audio compressor gain envelope: register file, envelope, multiply
// depends on acge_pkg, acge_cfg, acge_env, acge_scale
//
//   channel  ports                              width  direction
//   in       in_valid / in_ready / in_sample_in  32 s   request in
//   out      out_valid / out_ready / out_sample_out 32 s result out
//   cfg      cfg_we / cfg_index / cfg_wdata      3, 32  write only
//
// one request per cycle sustained while out_ready is high
// stages: input register, envelope update into multiply register, product into result register
// the gain envelope advances as a request leaves the input register, one step per request
// reset is synchronous; all stages empty and the gain at unity afterwards
// a stalled result backs up through the stages; in_ready falls only when all three are full
module audio_compressor_gain_envelope (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [acge_pkg::SampleW-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [acge_pkg::SampleW-1:0] out_sample_out,
  input  logic                                cfg_we,
  input  logic [acge_pkg::IdxW-1:0]           cfg_index,
  input  logic [acge_pkg::SampleW-1:0]        cfg_wdata
);

  acge_pkg::cfg_t                     cfg;

  logic                               s0_vld_r;
  logic                               s0_neg_r;
  logic [acge_pkg::SampleW-1:0]       s0_mag_r;
  logic                               s1_vld_r;
  logic                               s1_neg_r;
  logic [acge_pkg::SampleW-1:0]       s1_mag_r;
  logic [acge_pkg::GainW-1:0]         s1_gain_r;
  logic                               out_vld_r;
  logic signed [acge_pkg::SampleW-1:0] out_data_r;

  logic                               out_load_ok;
  logic                               s1_ready;
  logic                               s0_ready;
  logic                               s0_move;
  logic                               s1_move;
  logic [acge_pkg::SampleW-1:0]       in_raw;
  logic                               in_neg;
  logic [acge_pkg::SampleW-1:0]       in_mag;
  logic [acge_pkg::GainW-1:0]         gain_nxt;
  logic signed [acge_pkg::SampleW-1:0] scaled;

  assign out_load_ok = !out_vld_r || out_ready;
  assign s1_ready    = !s1_vld_r || out_load_ok;
  assign s0_ready    = !s0_vld_r || s1_ready;
  assign s0_move     = s0_vld_r && s1_ready;
  assign s1_move     = s1_vld_r && out_load_ok;

  assign in_ready    = s0_ready;
  assign out_valid   = out_vld_r;
  assign out_sample_out = out_data_r;

  // magnitude of the minimum value wraps to itself, which is 2^31 unsigned
  assign in_raw = unsigned'(in_sample_in);
  assign in_neg = in_raw[acge_pkg::SampleW-1];
  assign in_mag = in_neg ? (~in_raw + 32'd1) : in_raw;

  acge_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  acge_env u_env (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s0_move),
    .mag      (s0_mag_r),
    .cfg      (cfg),
    .gain_nxt (gain_nxt)
  );

  acge_scale u_scale (
    .neg        (s1_neg_r),
    .mag        (s1_mag_r),
    .gain       (s1_gain_r),
    .sample_out (scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_ready) s0_vld_r <= in_valid;
      if (s1_ready) s1_vld_r <= s0_vld_r;
      if (out_load_ok) out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_ready) begin
      s0_neg_r <= in_neg;
      s0_mag_r <= in_mag;
    end
    if (s0_move) begin
      s1_neg_r  <= s0_neg_r;
      s1_mag_r  <= s0_mag_r;
      s1_gain_r <= gain_nxt;
    end
    if (s1_move) begin
      out_data_r <= scaled;
    end
  end

endmodule

>>> design/acge_checker.sv
// port-level checks for the compressor top level, bound to every instance
// depends on acge_pkg and the top level's ports
module acge_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [acge_pkg::SampleW-1:0] out_sample_out
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // input backs up only when the result is held
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)))
    else $error("stalled result changed");

endmodule

bind audio_compressor_gain_envelope acge_checker u_acge_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);
